>>> rtl/wlm_pkg.sv
// Shared types and constants for the windowed local-maximum flagger.
// Holds field widths, status codes and the window entry and result records.
// No dependencies.
package wlm_pkg;

	localparam int CHROM_W  = 16;
	localparam int COORD_W  = 31;
	localparam int SCORE_W  = 32;
	localparam int SEQ_W    = 32;
	localparam int STATUS_W = 3;
	// Compare unit works one bit wider than the widest operand.
	localparam int CMP_W    = SCORE_W + 1;

	localparam int DEFAULT_WINDOW_DEPTH = 32;
	localparam logic [COORD_W-1:0] RANGE_RESET = COORD_W'(1);

	typedef enum logic [STATUS_W-1:0] {
		ST_OK          = 3'd0,
		ST_CHROM_ORDER = 3'd1,
		ST_START_ORDER = 3'd2,
		ST_NESTED      = 3'd3,
		ST_OVERFLOW    = 3'd4
	} wlm_status_t;

	typedef struct packed {
		logic [CHROM_W-1:0]        chrom;
		logic [COORD_W-1:0]        region_end;
		logic signed [SCORE_W-1:0] score;
	} wlm_entry_t;

	typedef struct packed {
		logic [SEQ_W-1:0] seq;
		logic             is_max;
		wlm_status_t      status;
	} wlm_res_t;

	// Sequencer to output stage.
	typedef struct packed {
		logic     push;
		logic     close;
		wlm_res_t res;
	} wlm_req_t;

	// Output stage to sequencer.
	typedef struct packed {
		logic push_ok;
		logic close_ok;
	} wlm_ack_t;

endpackage

>>> rtl/wlm_window_mem.sv
// Storage for pending regions: one write port, one registered read port.
// Depends on wlm_pkg for the entry record.
module wlm_window_mem #(
	parameter int DEPTH = wlm_pkg::DEFAULT_WINDOW_DEPTH
) (
	input  logic                       clk,
	input  logic                       wr_en,
	input  logic [$clog2(DEPTH)-1:0]   wr_addr,
	input  wlm_pkg::wlm_entry_t        wr_data,
	input  logic                       rd_en,
	input  logic [$clog2(DEPTH)-1:0]   rd_addr,
	output wlm_pkg::wlm_entry_t        rd_data
);
	import wlm_pkg::*;

	wlm_entry_t mem_q [DEPTH];
	wlm_entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> rtl/wlm_cmp_unit.sv
// Shared subtract-and-compare unit: diff = a - b, tested against a threshold.
// Used for the gap test on retirement and for score compares. Depends on wlm_pkg.
module wlm_cmp_unit (
	input  logic signed [wlm_pkg::CMP_W-1:0] op_a,
	input  logic signed [wlm_pkg::CMP_W-1:0] op_b,
	input  logic signed [wlm_pkg::CMP_W-1:0] thr,
	output logic                             gt,
	output logic                             neg
);
	import wlm_pkg::*;

	logic signed [CMP_W-1:0] diff;

	// Operands never exceed CMP_W-1 bits of magnitude, so diff cannot overflow.
	assign diff = op_a - op_b;
	assign gt   = diff > thr;
	assign neg  = diff[CMP_W-1];

endmodule

>>> rtl/wlm_out_stage.sv
// Result holding register and output register.
// One result is held back until it is known whether it ends the run. Depends on wlm_pkg.
module wlm_out_stage (
	input  logic                                clk,
	input  logic                                arst_n,
	input  wlm_pkg::wlm_req_t                   req,
	output wlm_pkg::wlm_ack_t                   ack,
	output logic                                out_valid,
	input  logic                                out_stall,
	output wlm_pkg::wlm_res_t                   out_res,
	output logic                                out_last
);
	import wlm_pkg::*;

	logic     hold_v_q;
	wlm_res_t hold_q;
	logic     out_valid_q;
	wlm_res_t out_res_q;
	logic     out_last_q;
	logic     out_free;
	logic     out_load;

	assign out_free     = !out_valid_q || !out_stall;
	assign ack.push_ok  = !hold_v_q || out_free;
	assign ack.close_ok = !hold_v_q || out_free;

	// Held result moves to the output on a new push or on close.
	assign out_load = hold_v_q && ((req.push && ack.push_ok) || (req.close && out_free));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (req.push && ack.push_ok) begin
				hold_v_q <= 1'b1;
			end else if (req.close && hold_v_q && out_free) begin
				hold_v_q <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.push && ack.push_ok) begin
			hold_q <= req.res;
			if (hold_v_q) begin
				out_res_q  <= hold_q;
				out_last_q <= 1'b0;
			end
		end else if (req.close && hold_v_q && out_free) begin
			out_res_q  <= hold_q;
			out_last_q <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_res_q;
	assign out_last  = out_last_q;

endmodule

>>> rtl/windowed_local_maximum_flagger.sv
// Throughput: one item at a time, paced by the single window read port and the
// shared compare unit.
// Reset: window empty, range 1, sequence count 0; window storage is not cleared.
// Uses wlm_pkg, wlm_window_mem, wlm_cmp_unit and wlm_out_stage.
module windowed_local_maximum_flagger #(
	parameter int WINDOW_DEPTH = wlm_pkg::DEFAULT_WINDOW_DEPTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration write
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [wlm_pkg::COORD_W-1:0]         neighbour_range,
	// input items
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                flush,
	input  logic [wlm_pkg::CHROM_W-1:0]         chrom_id,
	input  logic [wlm_pkg::COORD_W-1:0]         region_start,
	input  logic [wlm_pkg::COORD_W-1:0]         region_end,
	input  logic signed [wlm_pkg::SCORE_W-1:0]  score,
	// results
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [wlm_pkg::SEQ_W-1:0]           region_seq,
	output logic                                is_max,
	output logic [wlm_pkg::STATUS_W-1:0]        status,
	output logic                                last_of_run
);
	import wlm_pkg::*;

	localparam int PW = $clog2(WINDOW_DEPTH);
	localparam int CW = $clog2(WINDOW_DEPTH + 1);
	localparam logic [CW-1:0] FULL = CW'(WINDOW_DEPTH);

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,     // sort-order check, pick flush, error or region path
		S_FLUSH,     // retire everything, one per cycle unless the output stage holds off
		S_ERR,       // single error result
		S_RET_RD,    // read head entry
		S_RET_CHK,   // gap / chromosome test on head, retire if out of reach
		S_OVF,       // evict oldest if still full
		S_CMP_INIT,
		S_CMP_RD,    // read one pending entry
		S_CMP_CHK,   // score compare both ways
		S_INSERT,    // append incoming region
		S_CLOSE      // release last held result with last_of_run
	} state_t;

	state_t            state_q;
	logic [COORD_W-1:0] range_q;
	logic [PW-1:0]     head_q, tail_q, scan_q;
	logic [CW-1:0]     count_q, idx_q;
	logic [SEQ_W-1:0]  next_seq_q;
	logic [CHROM_W-1:0] prev_chrom_q;
	logic [COORD_W-1:0] prev_start_q, prev_end_q;
	logic              seen_q;
	logic              bn_q;        // incoming region beaten so far
	wlm_status_t       err_q;

	// latched item, no reset
	logic              in_flush_q;
	logic [CHROM_W-1:0] in_chrom_q;
	logic [COORD_W-1:0] in_start_q, in_end_q;
	logic signed [SCORE_W-1:0] in_score_q;
	logic [WINDOW_DEPTH-1:0] beaten_q;

	logic              accept;
	wlm_status_t       order_err;
	logic [SEQ_W-1:0]  seq_old;
	logic              retire_hit;

	logic              rd_en, wr_en;
	logic [PW-1:0]     rd_addr;
	wlm_entry_t        rd_data, wr_data;

	logic signed [CMP_W-1:0] cmp_a, cmp_b, cmp_thr;
	logic              cmp_gt, cmp_neg;

	wlm_req_t          req;
	wlm_ack_t          ack;
	wlm_res_t          out_res;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		ptr_inc = (p == PW'(WINDOW_DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	assign in_stall  = (state_q != S_IDLE);
	assign cfg_ready = (state_q == S_IDLE);
	assign accept    = in_valid && !in_stall;

	// Sequence number of the oldest pending region.
	assign seq_old = next_seq_q - SEQ_W'(count_q);

	always_comb begin
		order_err = ST_OK;
		if (in_chrom_q < prev_chrom_q) begin
			order_err = ST_CHROM_ORDER;
		end else if (in_chrom_q == prev_chrom_q && in_start_q < prev_start_q) begin
			order_err = ST_START_ORDER;
		end else if (in_chrom_q == prev_chrom_q && in_end_q < prev_end_q) begin
			order_err = ST_NESTED;
		end
	end

	// Shared compare unit: score compare in S_CMP_CHK, gap test otherwise.
	always_comb begin
		if (state_q == S_CMP_CHK) begin
			cmp_a   = CMP_W'(in_score_q);
			cmp_b   = CMP_W'(rd_data.score);
			cmp_thr = '0;
		end else begin
			cmp_a   = $signed({2'b00, in_start_q});
			cmp_b   = $signed({2'b00, rd_data.region_end});
			cmp_thr = $signed({2'b00, range_q});
		end
	end

	wlm_cmp_unit u_cmp (
		.op_a (cmp_a),
		.op_b (cmp_b),
		.thr  (cmp_thr),
		.gt   (cmp_gt),
		.neg  (cmp_neg)
	);

	assign retire_hit = (rd_data.chrom != in_chrom_q) || cmp_gt;

	// Window memory ports and result requests.
	always_comb begin
		rd_en       = 1'b0;
		rd_addr     = head_q;
		req.push    = 1'b0;
		req.close   = 1'b0;
		req.res.seq    = seq_old;
		req.res.is_max = !beaten_q[head_q];
		req.res.status = ST_OK;
		case (state_q)
			S_RET_RD: begin
				rd_en = (count_q != '0);
			end
			S_RET_CHK: begin
				req.push = retire_hit;
			end
			S_OVF: begin
				req.push       = (count_q == FULL);
				req.res.status = ST_OVERFLOW;
			end
			S_CMP_RD: begin
				rd_en   = 1'b1;
				rd_addr = scan_q;
			end
			S_FLUSH: begin
				req.push = (count_q != '0);
			end
			S_ERR: begin
				req.push       = 1'b1;
				req.res.seq    = '0;
				req.res.is_max = 1'b0;
				req.res.status = err_q;
			end
			S_CLOSE: begin
				req.close = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign wr_en = (state_q == S_INSERT);
	assign wr_data.chrom      = in_chrom_q;
	assign wr_data.region_end = in_end_q;
	assign wr_data.score      = in_score_q;

	wlm_window_mem #(
		.DEPTH (WINDOW_DEPTH)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (tail_q),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			range_q      <= RANGE_RESET;
			head_q       <= '0;
			tail_q       <= '0;
			scan_q       <= '0;
			count_q      <= '0;
			idx_q        <= '0;
			next_seq_q   <= '0;
			prev_chrom_q <= '0;
			prev_start_q <= '0;
			prev_end_q   <= '0;
			seen_q       <= 1'b0;
			bn_q         <= 1'b0;
			err_q        <= ST_OK;
		end else begin
			if (cfg_valid && cfg_ready) begin
				range_q <= neighbour_range;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (in_flush_q) begin
						state_q <= S_FLUSH;
					end else if (seen_q && order_err != ST_OK) begin
						err_q   <= order_err;
						state_q <= S_ERR;
					end else begin
						state_q <= S_RET_RD;
					end
				end
				S_FLUSH: begin
					if (count_q == '0) begin
						seen_q       <= 1'b0;
						prev_chrom_q <= '0;
						prev_start_q <= '0;
						prev_end_q   <= '0;
						state_q      <= S_CLOSE;
					end else if (ack.push_ok) begin
						head_q  <= ptr_inc(head_q);
						count_q <= count_q - CW'(1);
					end
				end
				S_ERR: begin
					if (ack.push_ok) begin
						state_q <= S_CLOSE;
					end
				end
				S_RET_RD: begin
					state_q <= (count_q == '0) ? S_OVF : S_RET_CHK;
				end
				S_RET_CHK: begin
					if (retire_hit) begin
						if (ack.push_ok) begin
							head_q  <= ptr_inc(head_q);
							count_q <= count_q - CW'(1);
							state_q <= S_RET_RD;
						end
					end else begin
						state_q <= S_OVF;
					end
				end
				S_OVF: begin
					if (count_q == FULL) begin
						if (ack.push_ok) begin
							head_q  <= ptr_inc(head_q);
							count_q <= count_q - CW'(1);
							state_q <= S_CMP_INIT;
						end
					end else begin
						state_q <= S_CMP_INIT;
					end
				end
				S_CMP_INIT: begin
					scan_q  <= head_q;
					idx_q   <= '0;
					bn_q    <= 1'b0;
					state_q <= (count_q == '0) ? S_INSERT : S_CMP_RD;
				end
				S_CMP_RD: begin
					state_q <= S_CMP_CHK;
				end
				S_CMP_CHK: begin
					if (cmp_neg) begin
						bn_q <= 1'b1;
					end
					scan_q  <= ptr_inc(scan_q);
					idx_q   <= idx_q + CW'(1);
					state_q <= (idx_q + CW'(1) == count_q) ? S_INSERT : S_CMP_RD;
				end
				S_INSERT: begin
					tail_q       <= ptr_inc(tail_q);
					count_q      <= count_q + CW'(1);
					next_seq_q   <= next_seq_q + SEQ_W'(1);
					prev_chrom_q <= in_chrom_q;
					prev_start_q <= in_start_q;
					prev_end_q   <= in_end_q;
					seen_q       <= 1'b1;
					state_q      <= S_CLOSE;
				end
				S_CLOSE: begin
					if (ack.close_ok) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Item latch and beaten flags (payload, no reset).
	always_ff @(posedge clk) begin
		if (accept) begin
			in_flush_q <= flush;
			in_chrom_q <= chrom_id;
			in_start_q <= region_start;
			in_end_q   <= region_end;
			in_score_q <= score;
		end
		// Incoming score beats a pending one.
		if (state_q == S_CMP_CHK && cmp_gt) begin
			beaten_q[scan_q] <= 1'b1;
		end
		if (state_q == S_INSERT) begin
			beaten_q[tail_q] <= bn_q;
		end
	end

	wlm_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.ack       (ack),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_res   (out_res),
		.out_last  (last_of_run)
	);

	assign region_seq = out_res.seq;
	assign is_max     = out_res.is_max;
	assign status     = out_res.status;

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL)
		else $error("window count above depth");

	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (head_q == tail_q))
		else $error("empty window with head and tail apart");

	a_insert_room: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INSERT) |-> (count_q < FULL))
		else $error("insert into a full window");

	a_retire_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(req.push && (state_q == S_RET_CHK || state_q == S_FLUSH || state_q == S_OVF))
		|-> (count_q != '0))
		else $error("retire from an empty window");

	a_seq_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INSERT) |=> (next_seq_q == $past(next_seq_q) + SEQ_W'(1)))
		else $error("sequence count did not advance on insert");
`endif

endmodule

>>> sim/windowed_local_maximum_flagger_tb.sv
// Self-checking testbench for windowed_local_maximum_flagger.
// Drives region streams with random pacing and checks each verdict against a
// behavioral predictor. Depends on wlm_pkg and the flagger RTL.
`timescale 1ns / 100ps

module windowed_local_maximum_flagger_tb;
	import wlm_pkg::*;

	localparam int WIN            = DEFAULT_WINDOW_DEPTH;
	// Settling pad, well beyond the worst item including its output stalls.
	localparam int SETTLE_PAD     = 200;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam logic [COORD_W-1:0] BASE_MASK = 31'h7FF0_0000;

	typedef struct {
		logic                      flush;
		logic [CHROM_W-1:0]        chrom;
		logic [COORD_W-1:0]        start_pos;
		logic [COORD_W-1:0]        end_pos;
		logic signed [SCORE_W-1:0] metric;
	} region_item_t;

	typedef struct {
		logic [SEQ_W-1:0] seq;
		logic             peak;
		wlm_status_t      code;
		logic             closes_run;
	} region_verdict_t;

	// DUT signals; every input is known from time zero
	logic                       clk             = 1'b0;
	logic                       arst_n          = 1'b0;
	logic                       cfg_valid       = 1'b0;
	logic                       cfg_ready;
	logic [COORD_W-1:0]         neighbour_range = '0;
	logic                       in_valid        = 1'b0;
	logic                       in_stall;
	logic                       flush           = 1'b0;
	logic [CHROM_W-1:0]         chrom_id        = '0;
	logic [COORD_W-1:0]         region_start    = '0;
	logic [COORD_W-1:0]         region_end      = '0;
	logic signed [SCORE_W-1:0]  score           = '0;
	logic                       out_valid;
	logic                       out_stall       = 1'b0;
	logic [SEQ_W-1:0]           region_seq;
	logic                       is_max;
	logic [STATUS_W-1:0]        status;
	logic                       last_of_run;

	// Predictor copy of the window and stream state
	logic [CHROM_W-1:0]        win_chrom  [WIN];
	logic [COORD_W-1:0]        win_end    [WIN];
	logic signed [SCORE_W-1:0] win_score  [WIN];
	logic                      win_beaten [WIN];
	int                        win_count   = 0;
	logic [CHROM_W-1:0]        last_chrom  = '0;
	logic [COORD_W-1:0]        last_start  = '0;
	logic [COORD_W-1:0]        last_end    = '0;
	logic                      stream_open = 1'b0;
	logic [SEQ_W-1:0]          seq_next    = '0;
	logic [COORD_W-1:0]        range_cfg   = RANGE_RESET;

	region_item_t    outgoing[$];          // regions waiting to be driven
	region_item_t    staged;
	region_verdict_t step_verdicts[$];     // verdicts produced by one transfer
	region_verdict_t awaited_verdicts[$];  // verdicts not yet seen on the output

	// Handshake flags, registered at the rising edge and read at the falling edge
	logic item_taken = 1'b0;
	logic res_taken  = 1'b0;
	logic cfg_took   = 1'b0;

	bit jitter_on    = 1'b0;   // random idling on both sides
	int send_gap     = 0;
	int rx_wait      = 0;
	int hold_request = 0;      // bumped by the stimulus to ask for a long output stall
	int hold_served  = 0;
	int hold_left    = 0;
	int quiet_cycles = 0;
	int fail_count   = 0;

	windowed_local_maximum_flagger #(.WINDOW_DEPTH(WIN)) uut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.neighbour_range (neighbour_range),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.flush           (flush),
		.chrom_id        (chrom_id),
		.region_start    (region_start),
		.region_end      (region_end),
		.score           (score),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.region_seq      (region_seq),
		.is_max          (is_max),
		.status          (status),
		.last_of_run     (last_of_run)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// Oldest pending region leaves the window with its verdict so far.
	task automatic retire_oldest(input wlm_status_t code);
		region_verdict_t v;
		int j;
		v.seq        = seq_next - SEQ_W'(win_count);
		v.peak       = !win_beaten[0];
		v.code       = code;
		v.closes_run = 1'b0;
		step_verdicts.push_back(v);
		for (j = 1; j < win_count; j++) begin
			win_chrom[j-1]  = win_chrom[j];
			win_end[j-1]    = win_end[j];
			win_score[j-1]  = win_score[j];
			win_beaten[j-1] = win_beaten[j];
		end
		win_count--;
	endtask

	// Updates the window for one accepted transfer and queues its verdicts.
	task automatic flag_maxima(input region_item_t it);
		region_verdict_t v;
		wlm_status_t     fault;
		logic            newcomer_beaten;
		int              j;
		step_verdicts.delete();
		if (it.flush) begin
			while (win_count > 0)
				retire_oldest(ST_OK);
			stream_open = 1'b0;
			last_chrom  = '0;
			last_start  = '0;
			last_end    = '0;
		end else begin
			fault = ST_OK;
			if (stream_open) begin
				if (it.chrom < last_chrom)
					fault = ST_CHROM_ORDER;
				else if (it.chrom == last_chrom && it.start_pos < last_start)
					fault = ST_START_ORDER;
				else if (it.chrom == last_chrom && it.end_pos < last_end)
					fault = ST_NESTED;
			end
			if (fault != ST_OK) begin
				// Rejected region: one error verdict, state untouched
				v.seq        = '0;
				v.peak       = 1'b0;
				v.code       = fault;
				v.closes_run = 1'b0;
				step_verdicts.push_back(v);
			end else begin
				// Drop everything that can no longer neighbour this region.
				// Gaps are signed, so touching or overlapping regions count.
				while (win_count > 0 && (win_chrom[0] != it.chrom ||
						longint'(it.start_pos) - longint'(win_end[0]) >
						longint'(range_cfg)))
					retire_oldest(ST_OK);
				// Still full: evict the oldest before it sees the newcomer
				if (win_count >= WIN)
					retire_oldest(ST_OVERFLOW);
				newcomer_beaten = 1'b0;
				for (j = 0; j < win_count; j++) begin
					if (it.metric > win_score[j])
						win_beaten[j] = 1'b1;
					if (win_score[j] > it.metric)
						newcomer_beaten = 1'b1;
				end
				win_chrom[win_count]  = it.chrom;
				win_end[win_count]    = it.end_pos;
				win_score[win_count]  = it.metric;
				win_beaten[win_count] = newcomer_beaten;
				win_count++;
				seq_next    = seq_next + 1'b1;
				last_chrom  = it.chrom;
				last_start  = it.start_pos;
				last_end    = it.end_pos;
				stream_open = 1'b1;
			end
		end
		if (step_verdicts.size() > 0)
			step_verdicts[step_verdicts.size()-1].closes_run = 1'b1;
		foreach (step_verdicts[j])
			awaited_verdicts.push_back(step_verdicts[j]);
	endtask

	// ------------------------------------------------------------------
	// Rising edge: sample transfers, predict, check, watchdog
	// ------------------------------------------------------------------
	always @(posedge clk) begin : sample_edge
		region_verdict_t want;
		if (arst_n) begin
			item_taken <= in_valid && !in_stall;
			res_taken  <= out_valid && !out_stall;
			cfg_took   <= cfg_valid && cfg_ready;

			if (cfg_valid && cfg_ready)
				range_cfg = neighbour_range;

			if (in_valid && !in_stall)
				flag_maxima('{flush, chrom_id, region_start, region_end, score});

			if (out_valid && !out_stall) begin
				if (awaited_verdicts.size() == 0) begin
					$error("unexpected result: region_seq %0d is_max %0d status %0d",
						region_seq, is_max, status);
					fail_count++;
				end else begin
					want = awaited_verdicts.pop_front();
					if (region_seq !== want.seq) begin
						$error("region_seq: expected %0d, got %0d", want.seq, region_seq);
						fail_count++;
					end
					if (is_max !== want.peak) begin
						$error("is_max: expected %0d, got %0d", want.peak, is_max);
						fail_count++;
					end
					if (status !== want.code) begin
						$error("status: expected %0d, got %0d", want.code, status);
						fail_count++;
					end
					if (last_of_run !== want.closes_run) begin
						$error("last_of_run: expected %0d, got %0d",
							want.closes_run, last_of_run);
						fail_count++;
					end
				end
			end

			// Any transfer counts as progress
			if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
					(cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Input driver: changes at the falling edge, holds a stalled transfer
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (!in_valid || item_taken) begin
			if (send_gap > 0) begin
				in_valid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (outgoing.size() > 0) begin
				staged = outgoing.pop_front();
				flush        <= staged.flush;
				chrom_id     <= staged.chrom;
				region_start <= staged.start_pos;
				region_end   <= staged.end_pos;
				score        <= staged.metric;
				in_valid     <= 1'b1;
				// idle time taken after this transfer completes
				send_gap     <= jitter_on ? $urandom_range(0, 7) : 0;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Result side pacing: long hold-off on request, else per-result stalls
	// ------------------------------------------------------------------
	always @(negedge clk) begin : pace_results
		int pause;
		if (hold_request != hold_served) begin
			hold_served <= hold_request;
			hold_left   <= HOLD_CYCLES;
			out_stall   <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else if (res_taken) begin
			pause = jitter_on ? $urandom_range(0, 7) : 0;
			out_stall <= (pause != 0);
			rx_wait   <= (pause > 0) ? pause - 1 : 0;
		end else if (rx_wait > 0) begin
			rx_wait   <= rx_wait - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	task automatic queue_region(input logic [CHROM_W-1:0] c, input logic [COORD_W-1:0] s,
			input logic [COORD_W-1:0] e, input logic signed [SCORE_W-1:0] m);
		outgoing.push_back('{1'b0, c, s, e, m});
	endtask

	task automatic queue_flush();
		// payload is don't-care on a flush; randomize it
		outgoing.push_back('{1'b1, CHROM_W'($urandom), COORD_W'($urandom),
			COORD_W'($urandom), SCORE_W'($urandom)});
	endtask

	// Register writes only happen while the block is idle.
	task automatic write_range(input logic [COORD_W-1:0] value);
		@(negedge clk);
		cfg_valid       <= 1'b1;
		neighbour_range <= value;
		do @(negedge clk); while (!cfg_took);
		cfg_valid <= 1'b0;
	endtask

	// Wait for all transfers and verdicts, then for any result-free item still in flight.
	task automatic settle();
		while (outgoing.size() != 0 || in_valid || awaited_verdicts.size() != 0)
			@(negedge clk);
		repeat (SETTLE_PAD) @(negedge clk);
	endtask

	// Mostly sorted regions with random content; some out-of-order ones and flushes.
	task automatic queue_stream(input int count, input int step_max, input int hop_odds);
		region_item_t     it;
		logic [CHROM_W-1:0] c;
		logic [COORD_W-1:0] s, e, reach;
		bit               opened;
		int               k, pick;
		c      = CHROM_W'($urandom);
		s      = COORD_W'($urandom) & BASE_MASK;
		e      = s;
		opened = 1'b0;
		for (k = 0; k < count; k++) begin
			pick      = $urandom_range(0, 99);
			it.flush  = 1'b0;
			it.chrom  = c;
			it.start_pos = s;
			it.end_pos   = e;
			// half full-range metrics, half from a tiny set so ties are common
			it.metric = $urandom_range(0, 1) ? SCORE_W'($urandom)
				: SCORE_W'($urandom_range(0, 6)) - 3;
			if (pick < 3) begin
				it.flush     = 1'b1;
				it.chrom     = CHROM_W'($urandom);
				it.start_pos = COORD_W'($urandom);
				it.end_pos   = COORD_W'($urandom);
				opened = 1'b0;
				c = CHROM_W'($urandom);
				s = COORD_W'($urandom) & BASE_MASK;
				e = s;
			end else if (pick < 12 && opened) begin
				// Broken order; where impossible this repeats the last region
				case (pick % 3)
					0: begin
						if (c != 0) begin
							it.chrom     = CHROM_W'($urandom_range(0, c - 1));
							it.start_pos = COORD_W'($urandom);
							it.end_pos   = COORD_W'($urandom);
						end
					end
					1: begin
						if (s != 0)
							it.start_pos = COORD_W'($urandom_range(0, s - 1));
					end
					default: begin
						if (e != 0)
							it.end_pos = COORD_W'($urandom_range(0, e - 1));
					end
				endcase
			end else begin
				if ($urandom_range(1, hop_odds) == 1 && c != 16'hFFFF) begin
					c = (c > 16'hFFF0) ? 16'hFFFF : c + CHROM_W'($urandom_range(1, 15));
					s = COORD_W'($urandom) & BASE_MASK;
					e = s;
				end else begin
					s = s + COORD_W'($urandom_range(0, step_max));
				end
				// a quarter keep the old end, which may leave it before the start
				if ($urandom_range(0, 3) != 0) begin
					reach = s + COORD_W'($urandom_range(0, 2 * step_max));
					if (reach > e)
						e = reach;
				end
				it.chrom     = c;
				it.start_pos = s;
				it.end_pos   = e;
				opened = 1'b1;
			end
			outgoing.push_back(it);
		end
		queue_flush();
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part at the reset range of 1, no idling
		queue_region(16'd0, 31'd0, 31'd0, 32'sh8000_0000);        // most negative metric
		queue_region(16'd0, 31'd0, 31'd5, 32'sh7FFF_FFFF);        // same start, longer
		queue_region(16'd0, 31'd4, 31'd5, 32'sh7FFF_FFFF);        // tie: both maxima
		queue_region(16'd0, 31'd3, 31'd9, 32'sd0);                // start out of order
		queue_region(16'd0, 31'd4, 31'd4, 32'sd0);                // nested region
		queue_region(16'd0, 31'd7, 31'd6, 32'sd5);                // end before start
		queue_region(16'd0, 31'd7, 31'd6, 32'sd5);                // exact repeat
		queue_region(16'd0, 31'd8, 31'd20, 32'sd9);
		queue_region(16'd3, 31'h7FFF_FFFF, 31'h7FFF_FFFF, -32'sd1); // chromosome change
		queue_region(16'd2, 31'd0, 31'd0, 32'sd0);                // chromosome out of order
		queue_region(16'hFFFF, 31'd0, 31'h7FFF_FFFF, 32'sd0);
		queue_region(16'hFFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 32'sd1);
		queue_flush();
		queue_flush();                                            // empty window: no result
		queue_region(16'd0, 31'd0, 31'd0, 32'sd1);                // new stream after flush
		queue_region(16'd0, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 32'sd0);
		queue_flush();
		settle();

		// Zero range: only touching or overlapping regions are neighbours
		write_range(31'd0);
		jitter_on = 1'b1;
		queue_stream(70, 3, 30);
		settle();

		// Full range: whole chromosomes are neighbours, window overflows.
		// The output is held off while input keeps coming, so the block backs up.
		write_range(31'h7FFF_FFFF);
		queue_stream(80, 50, 200);
		hold_request++;
		settle();

		write_range(31'd1);
		jitter_on = 1'b0;
		queue_stream(60, 4, 30);
		settle();

		write_range(COORD_W'($urandom_range(2, 40)));
		jitter_on = 1'b1;
		queue_stream(70, 16, 25);
		settle();

		write_range(COORD_W'($urandom));
		queue_stream(70, 1000, 40);
		hold_request++;
		settle();

		write_range(COORD_W'($urandom_range(1, 200)));
		queue_stream(70, 64, 30);
		settle();

		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

>>> windowed_local_maximum_flagger.f
rtl/wlm_pkg.sv
rtl/wlm_window_mem.sv
rtl/wlm_cmp_unit.sv
rtl/wlm_out_stage.sv
rtl/windowed_local_maximum_flagger.sv
sim/windowed_local_maximum_flagger_tb.sv
